### design/lpl_pkg.sv
`default_nettype none
package lpl_pkg;

  typedef struct packed {
    logic signed [23:0] left_in;
    logic signed [23:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] left_out;
    logic signed [23:0] right_out;
    logic signed [15:0] gain_now_db;
  } out_item_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] right;
    logic [24:0]        peak;
  } job_t;

  typedef enum logic [2:0] {
    REG_CEILING   = 3'd0,
    REG_LOOKAHEAD = 3'd1,
    REG_RELEASE   = 3'd2,
    REG_MODE      = 3'd3,
    REG_SLOPE     = 3'd4,
    REG_GATE_TH   = 3'd5,
    REG_GATE_ATT  = 3'd6,
    REG_TP_EN     = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_LIMIT = 2'd0,
    MODE_COMP  = 2'd1,
    MODE_GATE  = 2'd2,
    MODE_BYP   = 2'd3
  } mode_e;

  typedef struct packed {
    logic [22:0]        ceiling;
    logic [9:0]         lookahead_len;
    logic [15:0]        release_coeff;
    logic [1:0]         mode;
    logic [15:0]        comp_slope;
    logic [22:0]        gate_thresh;
    logic signed [15:0] gate_atten_db;
    logic               tp_en;
  } cfg_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_WRITE, BK_SCAN, BK_LOGP, BK_LOGC, BK_DB, BK_TGT, BK_REL,
    BK_LIN, BK_MUL, BK_OUT
  } bk_state_e;

  localparam logic [22:0] CEIL_MIN = 23'd8389;
  localparam logic [24:0] PEAK_MAX = 25'h1FFFFFF;
  localparam logic [15:0] LIMIT_SLOPE = 16'd64881;
  localparam logic [18:0] DB_PER_OCT = 19'd394566;
  localparam logic [13:0] OCT_PER_DB = 14'd10885;

  function automatic logic [16:0] log2_tab(input logic [4:0] i);
    case (i)
      5'd0: log2_tab = 17'd0;      5'd1: log2_tab = 17'd5732;
      5'd2: log2_tab = 17'd11136;  5'd3: log2_tab = 17'd16248;
      5'd4: log2_tab = 17'd21098;  5'd5: log2_tab = 17'd25711;
      5'd6: log2_tab = 17'd30109;  5'd7: log2_tab = 17'd34312;
      5'd8: log2_tab = 17'd38336;  5'd9: log2_tab = 17'd42196;
      5'd10: log2_tab = 17'd45904; 5'd11: log2_tab = 17'd49472;
      5'd12: log2_tab = 17'd52911; 5'd13: log2_tab = 17'd56229;
      5'd14: log2_tab = 17'd59434; 5'd15: log2_tab = 17'd62534;
      default: log2_tab = 17'd65536;
    endcase
  endfunction

  function automatic logic [16:0] exp2n_tab(input logic [4:0] i);
    case (i)
      5'd0: exp2n_tab = 17'd65536;  5'd1: exp2n_tab = 17'd62757;
      5'd2: exp2n_tab = 17'd60097;  5'd3: exp2n_tab = 17'd57549;
      5'd4: exp2n_tab = 17'd55109;  5'd5: exp2n_tab = 17'd52773;
      5'd6: exp2n_tab = 17'd50535;  5'd7: exp2n_tab = 17'd48392;
      5'd8: exp2n_tab = 17'd46341;  5'd9: exp2n_tab = 17'd44376;
      5'd10: exp2n_tab = 17'd42495; 5'd11: exp2n_tab = 17'd40693;
      5'd12: exp2n_tab = 17'd38968; 5'd13: exp2n_tab = 17'd37316;
      5'd14: exp2n_tab = 17'd35734; 5'd15: exp2n_tab = 17'd34219;
      default: exp2n_tab = 17'd32768;
    endcase
  endfunction

  // log2 of x (1 <= x < 2^25) in Q16, table with 12-bit interpolation.
  function automatic logic [20:0] log2_q16(input logic [24:0] x);
    logic [4:0]  e;
    logic [30:0] m;
    logic [3:0]  idx;
    logic [11:0] low;
    logic [16:0] t0;
    logic [16:0] t1;
    logic [29:0] pr;
    e = 5'd0;
    for (int k = 0; k < 25; k++) begin
      if (x[k]) e = 5'(k);
    end
    m = 31'({6'd0, x} << (5'd30 - e));
    idx = m[29:26];
    low = m[25:14];
    t0 = log2_tab({1'b0, idx});
    t1 = log2_tab({1'b0, idx} + 5'd1);
    pr = 30'(t1 - t0) * 30'(low) + 30'd2048;
    log2_q16 = {e, 16'd0} + 21'(t0) + 21'(pr[29:12]);
  endfunction

endpackage
`default_nettype wire

### design/lookahead_peak_limiter_top.sv
`default_nettype none
// Stereo look-ahead peak limiter. Each input transaction carries one stereo
// pair in Q1.23 and yields exactly one output transaction with the pair from
// lookahead_len samples earlier, scaled by the current gain, plus that gain in
// Q7.8 dB. After reset the block clears its delay and peak memories and
// accepts no transaction during that pass. In the back part an item's time is
// set by the window scan that reads one stored peak per cycle from a single
// memory port; true-peak detection in the front part overlaps with the back
// part through a two-entry queue. The user must write configuration through
// cfg_we_i, cfg_idx_i and cfg_data_i only while idle; the block itself does
// not enforce this.
module lookahead_peak_limiter_top #(
  parameter int MAX_LOOKAHEAD = 512
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire [2:0]          cfg_idx_i,
  input  wire [22:0]         cfg_data_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  lpl_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output lpl_pkg::out_item_t out_data_o
);
  import lpl_pkg::*;

  cfg_t cfg_q;
  job_t f_job, b_job;
  logic f_valid, f_ready, b_valid, b_ready, clearing;
  logic fr_ready;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ceiling <= 23'd8388607;
      cfg_q.lookahead_len <= 10'd48;
      cfg_q.release_coeff <= 16'd68;
      cfg_q.mode <= MODE_LIMIT;
      cfg_q.comp_slope <= 16'd32768;
      cfg_q.gate_thresh <= 23'd0;
      cfg_q.gate_atten_db <= -16'sd15360;
      cfg_q.tp_en <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CEILING:   cfg_q.ceiling <= cfg_data_i;
        REG_LOOKAHEAD: cfg_q.lookahead_len <= cfg_data_i[9:0];
        REG_RELEASE:   cfg_q.release_coeff <= cfg_data_i[15:0];
        REG_MODE:      cfg_q.mode <= cfg_data_i[1:0];
        REG_SLOPE:     cfg_q.comp_slope <= cfg_data_i[15:0];
        REG_GATE_TH:   cfg_q.gate_thresh <= cfg_data_i;
        REG_GATE_ATT:  cfg_q.gate_atten_db <= cfg_data_i[15:0];
        REG_TP_EN:     cfg_q.tp_en <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The front part holds off while the memories are being cleared.
  assign in_ready_o = fr_ready && !clearing;

  lpl_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .tp_en_i(cfg_q.tp_en),
    .in_valid_i(in_valid_i && !clearing), .in_ready_o(fr_ready), .in_data_i(in_data_i),
    .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(f_job)
  );

  lpl_fifo u_fifo (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_job),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_job)
  );

  lpl_back #(.MaxLook(MAX_LOOKAHEAD)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_i(cfg_q),
    .job_valid_i(b_valid), .job_ready_o(b_ready), .job_i(b_job),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .clearing_o(clearing)
  );

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !in_ready_o) else $error("accepted during clearing");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.gain_now_db <= 16'sd0) else $error("gain positive");
endmodule
`default_nettype wire

### design/lpl_front.sv
`default_nettype none
// Front part: computes the peak of each pair (magnitude or true peak) and
// pushes a job into the queue.
module lpl_front (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              tp_en_i,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  lpl_pkg::in_item_t in_data_i,
  output logic             job_valid_o,
  input  wire              job_ready_i,
  output lpl_pkg::job_t    job_o
);
  import lpl_pkg::*;

  logic signed [23:0] hl_q [3];
  logic signed [23:0] hr_q [3];
  logic               busy_q;
  logic [1:0]         k_q;
  logic [24:0]        pl_q, pr_q;
  in_item_t           cur_q;
  logic               done_q;

  // One interpolation point per cycle for both channels.
  function automatic logic [25:0] tp_point(input logic signed [23:0] h0,
                                           input logic signed [23:0] h1,
                                           input logic signed [23:0] h2,
                                           input logic signed [23:0] h3,
                                           input logic [1:0] k);
    logic signed [35:0] a, b, c, v;
    logic signed [35:0] kk;
    kk = 36'(k);
    a = 36'(h2) - 36'(h0);
    b = 36'(h0) * 2 - 36'(h1) * 5 + 36'(h2) * 4 - 36'(h3);
    c = -36'(h0) + 36'(h1) * 3 - 36'(h2) * 3 + 36'(h3);
    v = 36'(h1) * 128 + a * (kk * 16) + b * (kk * kk * 4) + c * (kk * kk * kk);
    if (v < 0) v = -v;
    v = v + 36'sd64;
    tp_point = 26'(v >>> 7);
  endfunction

  function automatic logic [24:0] mag(input logic signed [23:0] x);
    mag = x[23] ? 25'(-{x[23], x}) : 25'(x);
  endfunction

  function automatic logic [24:0] sat_max(input logic [24:0] p, input logic [25:0] v);
    if (v > 26'(PEAK_MAX)) sat_max = PEAK_MAX;
    else if (25'(v) > p) sat_max = 25'(v);
    else sat_max = p;
  endfunction

  logic [25:0] vl, vr;
  assign vl = tp_point(hl_q[0], hl_q[1], hl_q[2], cur_q.left_in, k_q);
  assign vr = tp_point(hr_q[0], hr_q[1], hr_q[2], cur_q.right_in, k_q);

  assign in_ready_o = !busy_q && !done_q;
  assign job_valid_o = done_q;
  assign job_o.left = cur_q.left_in;
  assign job_o.right = cur_q.right_in;
  assign job_o.peak = (pl_q > pr_q) ? pl_q : pr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        hl_q[i] <= '0;
        hr_q[i] <= '0;
      end
    end else begin
      if (in_valid_i && in_ready_o) begin
        cur_q <= in_data_i;
        if (tp_en_i) begin
          busy_q <= 1'b1;
          k_q <= 2'd1;
          pl_q <= (mag(hl_q[1]) > mag(hl_q[2])) ? mag(hl_q[1]) : mag(hl_q[2]);
          pr_q <= (mag(hr_q[1]) > mag(hr_q[2])) ? mag(hr_q[1]) : mag(hr_q[2]);
        end else begin
          pl_q <= mag(in_data_i.left_in);
          pr_q <= mag(in_data_i.right_in);
          done_q <= 1'b1;
        end
      end
      if (busy_q) begin
        pl_q <= sat_max(pl_q, vl);
        pr_q <= sat_max(pr_q, vr);
        if (k_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          hl_q[0] <= hl_q[1]; hl_q[1] <= hl_q[2]; hl_q[2] <= cur_q.left_in;
          hr_q[0] <= hr_q[1]; hr_q[1] <= hr_q[2]; hr_q[2] <= cur_q.right_in;
        end
        k_q <= k_q + 2'd1;
      end
      if (done_q && job_ready_i) done_q <= 1'b0;
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !busy_q) else $error("front ready while busy");
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q)) else $error("front busy and done");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> k_q != 2'd0) else $error("front step index zero");
endmodule
`default_nettype wire

### design/lpl_fifo.sv
`default_nettype none
// Two-entry queue between front and back.
module lpl_fifo (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            wr_valid_i,
  output logic           wr_ready_o,
  input  lpl_pkg::job_t  wr_data_i,
  output logic           rd_valid_o,
  input  wire            rd_ready_i,
  output lpl_pkg::job_t  rd_data_o
);
  import lpl_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count out of range");
  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q) else $error("queue pointers");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && !rd) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("queue count step");
endmodule
`default_nettype wire

### design/lpl_back.sv
`default_nettype none
// Back part: delay lines, peak window scan, gain computer and output scaling.
module lpl_back #(
  parameter int MaxLook = 512
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  lpl_pkg::cfg_t     cfg_i,
  input  wire               job_valid_i,
  output logic              job_ready_o,
  input  lpl_pkg::job_t     job_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output lpl_pkg::out_item_t out_data_o,
  output logic              clearing_o
);
  import lpl_pkg::*;

  localparam int AW = $clog2(MaxLook);

  logic [47:0] dmem [MaxLook];
  logic [24:0] pmem [MaxLook];

  bk_state_e st_q, st_d;
  logic [AW-1:0] pos_q, ra_q;
  logic [AW:0]   len_q, cnt_q;
  logic          clr_q;
  logic [AW:0]   clr_cnt_q;
  job_t          job_q;
  logic [24:0]   pk_rd_q, maxp_q;
  logic [47:0]   d_rd_q;
  logic          rd_vld_q;
  logic [20:0]   lp_q, lc_q;
  logic signed [17:0] over_q;
  logic signed [16:0] tgt_q;
  logic signed [15:0] gain_q;
  logic [16:0]   lin_q;
  out_item_t     res_q;
  logic          ov_q;

  assign clearing_o = clr_q;
  assign job_ready_o = (st_q == BK_IDLE) && !clr_q;
  assign out_valid_o = ov_q;
  assign out_data_o = res_q;

  logic [22:0] ceil_eff;
  logic [AW:0] len_eff;
  assign ceil_eff = (cfg_i.ceiling < CEIL_MIN) ? CEIL_MIN : cfg_i.ceiling;
  always_comb begin
    if (cfg_i.lookahead_len == 10'd0) len_eff = (AW+1)'(1);
    else if (32'(cfg_i.lookahead_len) > MaxLook) len_eff = (AW+1)'(MaxLook);
    else len_eff = (AW+1)'(cfg_i.lookahead_len);
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE:  if (job_valid_i && !clr_q) st_d = BK_WRITE;
      BK_WRITE: st_d = BK_SCAN;
      BK_SCAN:  if (cnt_q == '0 && !rd_vld_q) st_d = BK_LOGP;
      BK_LOGP:  st_d = BK_LOGC;
      BK_LOGC:  st_d = BK_DB;
      BK_DB:    st_d = BK_TGT;
      BK_TGT:   st_d = BK_REL;
      BK_REL:   st_d = BK_LIN;
      BK_LIN:   st_d = BK_MUL;
      BK_MUL:   if (!ov_q) st_d = BK_OUT;
      BK_OUT:   st_d = BK_IDLE;
      default:  st_d = BK_IDLE;
    endcase
  end

  // Memory ports: one write and one read per cycle.
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [47:0]   mem_wd;
  logic [24:0]   mem_wp;
  always_comb begin
    mem_we = 1'b0;
    mem_wa = pos_q;
    mem_wd = {job_q.left, job_q.right};
    mem_wp = job_q.peak;
    mem_ra = ra_q;
    if (clr_q) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_q[AW-1:0];
      mem_wd = '0;
      mem_wp = '0;
    end else if (st_q == BK_WRITE) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dmem[mem_wa] <= mem_wd;
      pmem[mem_wa] <= mem_wp;
    end
    pk_rd_q <= pmem[mem_ra];
  end

  // Intermediate arithmetic.
  logic [21:0] diff;
  logic [40:0] over_p;
  logic [33:0] tprod;
  logic signed [17:0] tgt_c, dg;
  logic [33:0] rel_p;
  logic [29:0] n;
  logic [3:0]  eidx;
  logic [11:0] elow;
  logic [16:0] e0, e1, ev;
  logic [29:0] ep;
  logic [13:0] ip;
  logic [23:0] ml, mr;
  logic [40:0] pl, pr;
  logic signed [24:0] rl, rr;

  function automatic logic signed [23:0] sat24(input logic neg, input logic [40:0] p);
    logic [24:0] mg;
    mg = 25'(p[40:16]);
    if (p[40]) mg = 25'h1FFFFFF;
    if (neg) sat24 = (mg > 25'd8388608) ? -24'sd8388608 : 24'(-mg);
    else sat24 = (mg > 25'd8388607) ? 24'sd8388607 : 24'(mg);
  endfunction

  always_comb begin
    diff = (lp_q > lc_q) ? 22'(lp_q - lc_q) : 22'd0;
    over_p = 41'(diff) * 41'(DB_PER_OCT) + 41'd8388608;
    tprod = 34'(over_q) * 34'((cfg_i.mode == MODE_LIMIT) ? LIMIT_SLOPE : cfg_i.comp_slope)
            + 34'd32768;
    tgt_c = 18'sd0;
    if ((cfg_i.mode == MODE_LIMIT || cfg_i.mode == MODE_COMP) &&
        maxp_q > 25'(ceil_eff)) begin
      if (tprod[33:16] > 18'd32768) tgt_c = -18'sd32768;
      else tgt_c = -$signed({1'b0, tprod[32:16]});
    end
    if (cfg_i.mode == MODE_GATE && maxp_q < 25'(cfg_i.gate_thresh))
      tgt_c = (cfg_i.gate_atten_db > 0) ? 18'sd0 : 18'(cfg_i.gate_atten_db);
    dg = 18'(tgt_q) - 18'(gain_q);
    rel_p = 34'(dg) * 34'(cfg_i.release_coeff) + 34'd65535;
    n = 30'((30'(-17'(gain_q)) * 30'(OCT_PER_DB) + 30'd128) >> 8);
    ip = n[29:16];
    eidx = n[15:12];
    elow = n[11:0];
    e0 = exp2n_tab({1'b0, eidx});
    e1 = exp2n_tab({1'b0, eidx} + 5'd1);
    ep = 30'(e0 - e1) * 30'(elow) + 30'd2048;
    ev = e0 - 17'(ep[29:12]);
    ml = d_rd_q[47] ? 24'(-d_rd_q[47:24]) : d_rd_q[47:24];
    mr = d_rd_q[23] ? 24'(-d_rd_q[23:0]) : d_rd_q[23:0];
    pl = 41'(ml) * 41'(lin_q) + 41'd32768;
    pr = 41'(mr) * 41'(lin_q) + 41'd32768;
    rl = 25'(sat24(d_rd_q[47], pl));
    rr = 25'(sat24(d_rd_q[23], pr));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
      pos_q <= '0;
      clr_q <= 1'b1;
      clr_cnt_q <= '0;
      gain_q <= '0;
      ov_q <= 1'b0;
      cnt_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == (AW+1)'(MaxLook - 1)) clr_q <= 1'b0;
      end
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      rd_vld_q <= 1'b0;
      unique case (st_q)
        BK_IDLE: if (job_valid_i && !clr_q) begin
          job_q <= job_i;
          len_q <= len_eff;
        end
        BK_WRITE: begin
          maxp_q <= '0;
          ra_q <= pos_q;
          cnt_q <= len_q;
        end
        BK_SCAN: begin
          if (cnt_q != '0) begin
            rd_vld_q <= 1'b1;
            ra_q <= (ra_q == '0) ? AW'(MaxLook - 1) : ra_q - 1'b1;
            cnt_q <= cnt_q - 1'b1;
          end
          if (rd_vld_q && pk_rd_q > maxp_q) maxp_q <= pk_rd_q;
          if (cnt_q == '0 && !rd_vld_q) begin
            ra_q <= ({1'b0, pos_q} >= len_q) ? AW'({1'b0, pos_q} - len_q) :
                    AW'({1'b0, pos_q} + (AW+1)'(MaxLook) - len_q);
          end
        end
        BK_LOGP: begin
          lp_q <= log2_q16((maxp_q == '0) ? 25'd1 : maxp_q);
          d_rd_q <= dmem[ra_q];
        end
        BK_LOGC: lc_q <= log2_q16(25'(ceil_eff));
        BK_DB:   over_q <= 18'(over_p[40:24]);
        BK_TGT:  tgt_q <= 17'(tgt_c);
        BK_REL: begin
          if (tgt_q < 17'(gain_q)) gain_q <= 16'(tgt_q);
          else gain_q <= 16'(18'(gain_q) + 18'($signed(rel_p) >>> 16));
        end
        BK_LIN:  lin_q <= (ip >= 14'd40) ? 17'd0 : 17'(ev >> ip);
        BK_MUL: if (!ov_q) begin
          res_q.left_out <= 24'(rl);
          res_q.right_out <= 24'(rr);
          res_q.gain_now_db <= gain_q;
        end
        BK_OUT: begin
          ov_q <= 1'b1;
          pos_q <= (pos_q == AW'(MaxLook - 1)) ? '0 : pos_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_no_job_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> st_q == BK_IDLE) else $error("job during clearing");
  a_gain_nonpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_q <= 16'sd0) else $error("gain above zero dB");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == BK_OUT |-> !ov_q) else $error("result overwritten");
endmodule
`default_nettype wire
